@@ rtl/core/mmalu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmalu_pkg: shared types and microcode for the Montgomery modular ALU
// Holds widths, command codes, the control word layout and the microcode
// table that sequences the datapath through each command.
// ----------------------------------------------------------------------------
package mmalu_pkg;

  localparam int unsigned QW         = 31;  // residue and modulus width
  localparam int unsigned NinvW      = 32;  // -q^-1 mod 2^32
  localparam int unsigned CfgDataW   = 32;  // widest register
  localparam int unsigned CfgIdxW    = 2;   // four registers
  localparam int unsigned CmdW       = 3;
  localparam int unsigned ProdW      = 64;  // shared multiplier result
  localparam int unsigned ExpBitsDef = 31;
  localparam int unsigned PcW        = 6;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD       = 3'd0,
    CMD_SUB       = 3'd1,
    CMD_MONTMUL   = 3'd2,
    CMD_TO_MONT   = 3'd3,
    CMD_FROM_MONT = 3'd4,
    CMD_ROOT_POW  = 3'd5
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODULUS     = 2'd0,
    REG_NEG_INVERSE = 2'd1,
    REG_R_SQUARED   = 2'd2,
    REG_ROOT_MONT   = 2'd3
  } reg_e;

  // Datapath operation of one microcode step.
  typedef enum logic [3:0] {
    OP_NOP      = 4'd0,
    OP_ADD      = 4'd1,  // res = (a + b) reduced once
    OP_SUB      = 4'd2,  // res = a - b, plus q on borrow
    OP_ZERO     = 4'd3,  // res = 0
    OP_MUL_XY   = 4'd4,  // z = x * y
    OP_MUL_MN   = 4'd5,  // m = low32(z) * ninv mod 2^32
    OP_MUL_MQ   = 4'd6,  // prod = m * q
    OP_SUM      = 4'd7,  // t = (z + prod) >> 32
    OP_RED      = 4'd8,  // dst = t, minus q if t >= q
    OP_COPY_ACC = 4'd9   // res = acc
  } op_e;

  typedef enum logic [2:0] {
    SRC_A   = 3'd0,
    SRC_B   = 3'd1,
    SRC_ACC = 3'd2,
    SRC_P   = 3'd3,
    SRC_ONE = 3'd4,
    SRC_R2  = 3'd5
  } src_e;

  typedef enum logic [1:0] {
    DST_RES = 2'd0,
    DST_ACC = 2'd1,
    DST_P   = 2'd2
  } dst_e;

  typedef enum logic [2:0] {
    JMP_NONE   = 3'd0,
    JMP_ALWAYS = 3'd1,
    JMP_E_ZERO = 3'd2,  // exponent is zero
    JMP_E_LE1  = 3'd3,  // exponent is zero or one
    JMP_E_EVEN = 3'd4   // exponent low bit clear
  } jmp_e;

  typedef struct packed {
    op_e            op;
    src_e           src_x;
    src_e           src_y;
    dst_e           dst;
    jmp_e           jmp;
    logic [PcW-1:0] target;
    logic           shift_e;  // shift exponent right by one
    logic           done;     // last step: deliver the result
  } ctrl_t;

  // Microcode addresses.
  localparam logic [PcW-1:0] UA_ADD    = 6'd0;
  localparam logic [PcW-1:0] UA_SUB    = 6'd1;
  localparam logic [PcW-1:0] UA_ZERO   = 6'd2;
  localparam logic [PcW-1:0] UA_MUL    = 6'd3;   // montmul(a, b)
  localparam logic [PcW-1:0] UA_TOM    = 6'd8;   // montmul(a, r2)
  localparam logic [PcW-1:0] UA_FROMM  = 6'd13;  // montmul(a, 1)
  localparam logic [PcW-1:0] UA_ROOT   = 6'd18;  // acc = montmul(1, r2)
  localparam logic [PcW-1:0] UA_LOOP   = 6'd23;  // loop test
  localparam logic [PcW-1:0] UA_ODD    = 6'd24;  // acc = montmul(acc, p)
  localparam logic [PcW-1:0] UA_SQR    = 6'd29;  // p = montmul(p, p)
  localparam logic [PcW-1:0] UA_FIN    = 6'd34;  // res = montmul(p, acc)
  localparam logic [PcW-1:0] UA_EZERO  = 6'd39;  // res = acc

  localparam ctrl_t CtrlNop = '{
    op: OP_NOP, src_x: SRC_A, src_y: SRC_A, dst: DST_RES,
    jmp: JMP_NONE, target: '0, shift_e: 1'b0, done: 1'b0
  };

  // One step of a five-step Montgomery multiply.
  function automatic ctrl_t mm_word(logic [2:0] k, src_e x, src_e y, dst_e d);
    ctrl_t w;
    w       = CtrlNop;
    w.src_x = x;
    w.src_y = y;
    w.dst   = d;
    case (k)
      3'd0:    w.op = OP_MUL_XY;
      3'd1:    w.op = OP_MUL_MN;
      3'd2:    w.op = OP_MUL_MQ;
      3'd3:    w.op = OP_SUM;
      3'd4:    w.op = OP_RED;
      default: w.op = OP_NOP;
    endcase
    w.done = (k == 3'd4) && (d == DST_RES);
    return w;
  endfunction

  function automatic ctrl_t ucode_rom(logic [PcW-1:0] addr);
    ctrl_t w;
    w = CtrlNop;
    case (addr) inside
      UA_ADD:  begin
        w.op   = OP_ADD;
        w.done = 1'b1;
      end
      UA_SUB:  begin
        w.op   = OP_SUB;
        w.done = 1'b1;
      end
      UA_ZERO: begin
        w.op   = OP_ZERO;
        w.done = 1'b1;
      end
      [UA_MUL:UA_MUL+4]:     w = mm_word(3'(addr - UA_MUL), SRC_A, SRC_B, DST_RES);
      [UA_TOM:UA_TOM+4]:     w = mm_word(3'(addr - UA_TOM), SRC_A, SRC_R2, DST_RES);
      [UA_FROMM:UA_FROMM+4]: w = mm_word(3'(addr - UA_FROMM), SRC_A, SRC_ONE, DST_RES);
      [UA_ROOT:UA_ROOT+4]:   w = mm_word(3'(addr - UA_ROOT), SRC_ONE, SRC_R2, DST_ACC);
      UA_LOOP: begin
        w.jmp    = JMP_E_LE1;
        w.target = UA_FIN;
      end
      [UA_ODD:UA_ODD+4]:     w = mm_word(3'(addr - UA_ODD), SRC_ACC, SRC_P, DST_ACC);
      [UA_SQR:UA_SQR+4]:     w = mm_word(3'(addr - UA_SQR), SRC_P, SRC_P, DST_P);
      [UA_FIN:UA_FIN+4]:     w = mm_word(3'(addr - UA_FIN), SRC_P, SRC_ACC, DST_RES);
      UA_EZERO: begin
        w.op   = OP_COPY_ACC;
        w.done = 1'b1;
      end
      default: w = CtrlNop;
    endcase
    // Branches layered on the multiply sequences.
    if (addr == UA_ROOT + 6'd4) begin
      w.jmp    = JMP_E_ZERO;
      w.target = UA_EZERO;
    end
    if (addr == UA_ODD) begin
      w.jmp    = JMP_E_EVEN;
      w.target = UA_SQR;
    end
    if (addr == UA_SQR + 6'd4) begin
      w.shift_e = 1'b1;
      w.jmp     = JMP_ALWAYS;
      w.target  = UA_LOOP;
    end
    return w;
  endfunction

  function automatic logic [PcW-1:0] ucode_entry(cmd_e cmd);
    logic [PcW-1:0] a;
    case (cmd)
      CMD_ADD:       a = UA_ADD;
      CMD_SUB:       a = UA_SUB;
      CMD_MONTMUL:   a = UA_MUL;
      CMD_TO_MONT:   a = UA_TOM;
      CMD_FROM_MONT: a = UA_FROMM;
      CMD_ROOT_POW:  a = UA_ROOT;
      default:       a = UA_ZERO;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/montgomery_modular_alu_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// montgomery_modular_alu_core: microcoded Montgomery ALU for one residue lane
// Modular add, subtract, Montgomery multiply (R = 2^32), conversion into and
// out of Montgomery form, and powers of a configured root.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive cmd_i, operand_a_i, operand_b_i with start high;
//   a request is taken at a rising edge with start high and busy low. busy
//   stays high while the request runs.
//   Result channel: residue_o is shown for exactly one cycle, marked by
//   result_valid_o, in the cycle after the last microcode step. There is no
//   back pressure; the receiver must take the result in that cycle.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 modulus, 1 neg_inverse, 2 r_squared, 3 root_mont) at the clock edge.
//   Write only while idle.
// Microcode steps per command (one step per cycle while busy):
//   add, sub, unknown command: 1 step. montmul, to_mont, from_mont: 5 steps.
//   root_pow: 5 + 1 + 7 per zero bit / 11 per one bit below the top bit of
//   the exponent + 5, or 6 if it is zero; at most 341 for a 31-bit exponent.
//   The rate is set by the single shared 32x32 multiplier, used three times
//   per Montgomery product, with a sum and a reduction step after it.
// Reset: clears the sequencer and restores the register defaults
//   (modulus 3, neg_inverse 0x55555555, r_squared 1, root_mont 0).
// ----------------------------------------------------------------------------
module montgomery_modular_alu_core
  import mmalu_pkg::*;
#(
  parameter int unsigned EXP_BITS = ExpBitsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // request channel
  input  wire logic                start,
  output      logic                busy,
  input  wire logic [CmdW-1:0]     cmd_i,
  input  wire logic [QW-1:0]       operand_a_i,
  input  wire logic [QW-1:0]       operand_b_i,
  // result channel
  output      logic                result_valid_o,
  output      logic [QW-1:0]       residue_o,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [QW-1:0]    mod_q, mod_d;
  logic [NinvW-1:0] ninv_q, ninv_d;
  logic [QW-1:0]    r2_q, r2_d;
  logic [QW-1:0]    root_q, root_d;

  // Sequencer.
  logic             busy_q, busy_d;
  logic [PcW-1:0]   pc_q, pc_d;
  logic             valid_q, valid_d;
  ctrl_t            ctrl;
  logic             accept;
  logic             jump_take;

  // Datapath.
  logic [QW-1:0]       a_q, a_d;
  logic [QW-1:0]       b_q, b_d;
  logic [QW-1:0]       acc_q, acc_d;
  logic [QW-1:0]       p_q, p_d;
  logic [EXP_BITS-1:0] e_q, e_d;
  logic [2*QW-1:0]     z_q, z_d;        // product of two residues
  logic [NinvW-1:0]    m_q, m_d;
  logic [NinvW+QW-1:0] prod_q, prod_d;  // m * q
  logic [NinvW-1:0]    t_q, t_d;
  logic [QW-1:0]       res_q, res_d;

  logic [QW-1:0]       opx, opy;
  logic [31:0]         mul_x, mul_y;
  logic [ProdW-1:0]    mul_p;
  logic [ProdW-1:0]    sum_zp;
  logic [NinvW-1:0]    q_ext;
  logic [NinvW-1:0]    red_t;
  logic [QW:0]         add_s, add_r;
  logic [QW:0]         sub_d, sub_r;
  logic                e_zero, e_le1, e_even;

  assign accept = start && !busy_q;
  assign ctrl   = ucode_rom(pc_q);
  assign q_ext  = {1'b0, mod_q};

  // Pick operands for the first product of a Montgomery multiply.
  function automatic logic [QW-1:0] pick_src(src_e s, logic [QW-1:0] a,
                                             logic [QW-1:0] b,
                                             logic [QW-1:0] acc,
                                             logic [QW-1:0] p,
                                             logic [QW-1:0] r2);
    logic [QW-1:0] v;
    case (s)
      SRC_A:   v = a;
      SRC_B:   v = b;
      SRC_ACC: v = acc;
      SRC_P:   v = p;
      SRC_ONE: v = QW'(1);
      SRC_R2:  v = r2;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign opx = pick_src(ctrl.src_x, a_q, b_q, acc_q, p_q, r2_q);
  assign opy = pick_src(ctrl.src_y, a_q, b_q, acc_q, p_q, r2_q);

  // Shared multiplier: steer its inputs by the step's operation.
  always_comb begin
    case (ctrl.op)
      OP_MUL_XY: begin
        mul_x = {1'b0, opx};
        mul_y = {1'b0, opy};
      end
      OP_MUL_MN: begin
        mul_x = z_q[31:0];
        mul_y = ninv_q;
      end
      OP_MUL_MQ: begin
        mul_x = m_q;
        mul_y = q_ext;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p  = {32'd0, mul_x} * {32'd0, mul_y};

  // Montgomery tail: the 64-bit sum cannot carry out for in-range values.
  assign sum_zp = {2'b00, z_q} + {1'b0, prod_q};
  assign red_t  = (t_q >= q_ext) ? (t_q - q_ext) : t_q;

  assign add_s  = {1'b0, a_q} + {1'b0, b_q};
  assign add_r  = (add_s >= {1'b0, mod_q}) ? (add_s - {1'b0, mod_q}) : add_s;
  assign sub_d  = {1'b0, a_q} - {1'b0, b_q};
  assign sub_r  = (a_q < b_q) ? (sub_d + {1'b0, mod_q}) : sub_d;

  // Exponent tests for the square-and-multiply loop.
  assign e_zero = (e_q == '0);
  assign e_le1  = ((e_q >> 1) == '0);
  assign e_even = !e_q[0];

  always_comb begin
    case (ctrl.jmp)
      JMP_NONE:   jump_take = 1'b0;
      JMP_ALWAYS: jump_take = 1'b1;
      JMP_E_ZERO: jump_take = e_zero;
      JMP_E_LE1:  jump_take = e_le1;
      JMP_E_EVEN: jump_take = e_even;
      default:    jump_take = 1'b0;
    endcase
  end

  // Next-state logic: request load, one microcode step, config writes.
  always_comb begin
    busy_d  = busy_q;
    pc_d    = pc_q;
    valid_d = 1'b0;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    p_d     = p_q;
    e_d     = e_q;
    z_d     = z_q;
    m_d     = m_q;
    prod_d  = prod_q;
    t_d     = t_q;
    res_d   = res_q;
    mod_d   = mod_q;
    ninv_d  = ninv_q;
    r2_d    = r2_q;
    root_d  = root_q;

    if (accept) begin
      // Latch the request and jump to its microcode entry.
      busy_d = 1'b1;
      pc_d   = ucode_entry(cmd_e'(cmd_i));
      a_d    = operand_a_i;
      b_d    = operand_b_i;
      p_d    = root_q;
      e_d    = operand_b_i[EXP_BITS-1:0];
    end else if (busy_q) begin
      case (ctrl.op)
        OP_ADD:      res_d  = add_r[QW-1:0];
        OP_SUB:      res_d  = sub_r[QW-1:0];
        OP_ZERO:     res_d  = '0;
        OP_MUL_XY:   z_d    = mul_p[2*QW-1:0];
        OP_MUL_MN:   m_d    = mul_p[NinvW-1:0];
        OP_MUL_MQ:   prod_d = mul_p[NinvW+QW-1:0];
        OP_SUM:      t_d    = sum_zp[ProdW-1:NinvW];
        OP_RED: begin
          case (ctrl.dst)
            DST_RES: res_d = red_t[QW-1:0];
            DST_ACC: acc_d = red_t[QW-1:0];
            DST_P:   p_d   = red_t[QW-1:0];
            default: res_d = red_t[QW-1:0];
          endcase
        end
        OP_COPY_ACC: res_d  = acc_q;
        default:     res_d  = res_q;
      endcase
      if (ctrl.shift_e) begin
        e_d = e_q >> 1;
      end
      // Advance, branch, or finish.
      if (ctrl.done) begin
        busy_d  = 1'b0;
        valid_d = 1'b1;
      end else if (jump_take) begin
        pc_d = ctrl.target;
      end else begin
        pc_d = pc_q + PcW'(1);
      end
    end

    if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_MODULUS:     mod_d  = cfg_data_i[QW-1:0];
        REG_NEG_INVERSE: ninv_d = cfg_data_i[NinvW-1:0];
        REG_R_SQUARED:   r2_d   = cfg_data_i[QW-1:0];
        REG_ROOT_MONT:   root_d = cfg_data_i[QW-1:0];
        default:         mod_d  = mod_q;
      endcase
    end
  end

  // Control and configuration state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pc_q    <= '0;
      valid_q <= 1'b0;
      mod_q   <= QW'(3);
      ninv_q  <= 32'h5555_5555;
      r2_q    <= QW'(1);
      root_q  <= '0;
    end else begin
      busy_q  <= busy_d;
      pc_q    <= pc_d;
      valid_q <= valid_d;
      mod_q   <= mod_d;
      ninv_q  <= ninv_d;
      r2_q    <= r2_d;
      root_q  <= root_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
    p_q    <= p_d;
    e_q    <= e_d;
    z_q    <= z_d;
    m_q    <= m_d;
    prod_q <= prod_d;
    t_q    <= t_d;
    res_q  <= res_d;
  end

  assign busy           = busy_q;
  assign result_valid_o = valid_q;
  assign residue_o      = res_q;

endmodule
`default_nettype wire
